// File: rtl/core/ple_pkg.sv
// ============================================================================
// ple_pkg: shared definitions of the positional list engine
// Operation codes, status codes, field widths and the cell shift modes.
// ============================================================================
`default_nettype none

package ple_pkg;

  // Default list depth.
  localparam int CAPACITY_DEF = 16;

  // Field widths.
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;

  // Operation codes.
  localparam logic [KIND_W-1:0] K_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] K_INS_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] K_INS_POS   = 3'd2;
  localparam logic [KIND_W-1:0] K_DEL_FRONT = 3'd3;
  localparam logic [KIND_W-1:0] K_DEL_BACK  = 3'd4;
  localparam logic [KIND_W-1:0] K_DEL_POS   = 3'd5;
  localparam logic [KIND_W-1:0] K_DUMP      = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // What the whole chain does in a given cycle.
  typedef logic [1:0] cell_mode_t;
  localparam cell_mode_t M_KEEP = 2'd0;
  localparam cell_mode_t M_INS  = 2'd1;
  localparam cell_mode_t M_DEL  = 2'd2;
  localparam cell_mode_t M_ROT  = 2'd3;

endpackage

`default_nettype wire

// File: rtl/core/ple_req_if.sv
// ============================================================================
// ple_req_if: request channel of the positional list engine
// Valid/ready channel carrying one list operation per beat.
// ============================================================================
`default_nettype none

interface ple_req_if
  import ple_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]    position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ple_rsp_if.sv
// ============================================================================
// ple_rsp_if: response channel of the positional list engine
// Valid/ready channel carrying one result per beat.
// ============================================================================
`default_nettype none

interface ple_rsp_if
  import ple_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  entry_value;
  logic [ECOUNT_W-1:0]        entry_count;
  logic                       last;

  modport source (output valid, output status, output entry_value, output entry_count,
                  output last, input ready);
  modport sink   (input valid, input status, input entry_value, input entry_count,
                  input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/positional_list_engine.sv
// ============================================================================
// positional_list_engine: bounded ordered list held in a chain of cells
// Inserts, deletes and dumps signed 32-bit entries by 1-based position.
// ============================================================================
// Usage. Requests arrive on the req channel, one operation per beat: kind,
// value and position. Results leave on the rsp channel with status,
// entry_value, entry_count and last. Both channels are valid/ready, and a
// beat moves on a rising edge with valid and ready both high.
// Every operation except dump gives one result beat, which appears in the
// cycle after the request is taken. A dump gives one beat per entry; the
// dump state loads the first into the result register, then one per cycle
// while rsp is ready, front to back, with last on the final beat; an empty
// list dumps as one beat with the empty status, timed like the other results.
// Insert and delete shift all cells at once, so these operations run at one
// per cycle while the receiver keeps up. A dump occupies the block from the
// cycle in which the request is taken until its last beat, since the chain
// rotates by one cell per beat after that cycle.
// The block works on one request at a time: req.ready is low during a dump
// and whenever the result register holds a beat that rsp will not take.
// When the receiver stalls, the result register simply holds its beat and
// the chain waits with it; nothing is dropped.
// Reset (rst, synchronous, active high) empties the list and clears any
// pending beat. Cell contents are not cleared; they are only read below count.
// ============================================================================
`default_nettype none

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ple_req_if.sink    req,
  ple_rsp_if.source  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  // Control state.
  logic          state;
  logic [CW-1:0] count;
  logic [IW-1:0] dptr;
  logic          rsp_valid;

  // Result register payload.
  logic [STATUS_W-1:0] rsp_status;
  logic [VALUE_W-1:0]  rsp_value;
  logic [ECOUNT_W-1:0] rsp_count;
  logic                rsp_last;

  // The chain.
  logic [VALUE_W-1:0] data [CAPACITY];

  logic                take;
  logic                acc;
  logic                dump_beat;
  logic                dump_end;
  logic [8:0]          pos9;
  logic [8:0]          cnt9;
  logic                full;
  logic                empty;
  cell_mode_t          op_mode;
  cell_mode_t          chain_mode;
  logic [IW-1:0]       op_idx;
  logic [IW-1:0]       tail;
  logic [STATUS_W-1:0] op_status;
  logic [CW-1:0]       count_next;
  logic                start_dump;

  // The result register is free when empty or being drained this cycle.
  assign take      = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && take;
  assign acc       = req.valid && req.ready;
  assign dump_beat = (state == S_DUMP) && take;
  assign tail      = IW'(count - CW'(1));
  assign dump_end  = (dptr == tail);

  assign pos9  = {1'b0, req.position};
  assign cnt9  = 9'(count);
  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  // Decode of the request against the current fill level.
  always_comb begin
    op_mode    = M_KEEP;
    op_idx     = '0;
    op_status  = ST_OK;
    count_next = count;
    start_dump = 1'b0;
    unique case (req.kind)
      K_INS_FRONT, K_INS_BACK, K_INS_POS: begin
        // A full list refuses every insert before the position is looked at.
        if (full) begin
          op_status = ST_FULL;
        end else if (req.kind == K_INS_FRONT) begin
          op_mode    = M_INS;
          op_idx     = '0;
          count_next = count + CW'(1);
        end else if (req.kind == K_INS_BACK) begin
          op_mode    = M_INS;
          op_idx     = IW'(count);
          count_next = count + CW'(1);
        end else if (pos9 == 9'd0 || pos9 > cnt9 + 9'd1) begin
          op_status = ST_BADPOS;
        end else begin
          op_mode    = M_INS;
          op_idx     = IW'(pos9 - 9'd1);
          count_next = count + CW'(1);
        end
      end
      K_DEL_FRONT, K_DEL_BACK: begin
        if (empty) begin
          op_status = ST_EMPTY;
        end else begin
          op_mode    = M_DEL;
          op_idx     = (req.kind == K_DEL_FRONT) ? '0 : tail;
          count_next = count - CW'(1);
        end
      end
      K_DEL_POS: begin
        // Position zero is invalid even on an empty list.
        if (pos9 == 9'd0) begin
          op_status = ST_BADPOS;
        end else if (empty) begin
          op_status = ST_EMPTY;
        end else if (pos9 > cnt9) begin
          op_status = ST_BADPOS;
        end else begin
          op_mode    = M_DEL;
          op_idx     = IW'(pos9 - 9'd1);
          count_next = count - CW'(1);
        end
      end
      K_DUMP: begin
        if (empty) begin
          op_status = ST_EMPTY;
        end else begin
          start_dump = 1'b1;
        end
      end
      default: op_status = ST_BADPOS;
    endcase
  end

  // During a dump the chain rotates one cell per beat; after count beats
  // every entry is back in its place.
  always_comb begin
    chain_mode = M_KEEP;
    if (acc) begin
      chain_mode = op_mode;
    end else if (dump_beat) begin
      chain_mode = M_ROT;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_in;
    logic [VALUE_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = data[i];
    end else begin : g_inner_l
      assign left_in = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = data[i];
    end else begin : g_inner_r
      assign right_in = data[i+1];
    end
    ple_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .mode      (chain_mode),
      .idx       (op_idx),
      .tail      (tail),
      .new_value (req.value),
      .left      (left_in),
      .right     (right_in),
      .head      (data[0]),
      .data      (data[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dptr      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        count <= count_next;
        if (start_dump) begin
          state <= S_DUMP;
          dptr  <= '0;
        end
      end else if (dump_beat) begin
        dptr <= dptr + IW'(1);
        if (dump_end) begin
          state <= S_IDLE;
        end
      end
      // A new beat loads the result register; otherwise a taken beat empties it.
      if ((acc && !start_dump) || dump_beat) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (acc && !start_dump) begin
      rsp_status <= op_status;
      rsp_value  <= '0;
      rsp_count  <= ECOUNT_W'(count_next);
      rsp_last   <= 1'b1;
    end else if (dump_beat) begin
      rsp_status <= ST_OK;
      rsp_value  <= data[0];
      rsp_count  <= ECOUNT_W'(count);
      rsp_last   <= dump_end;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.entry_value = rsp_value;
  assign rsp.entry_count = rsp_count;
  assign rsp.last        = rsp_last;

endmodule

`default_nettype wire

// File: rtl/core/ple_cell.sv
// ============================================================================
// ple_cell: one storage cell of the list chain
// Holds one entry and picks its next value from itself, the new value or
// a neighbor, depending on the chain mode and its own place in the chain.
// ============================================================================
`default_nettype none

module ple_cell
  import ple_pkg::*;
#(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire cell_mode_t         mode,
  input  wire logic [IW-1:0]      idx,
  input  wire logic [IW-1:0]      tail,
  input  wire logic [VALUE_W-1:0] new_value,
  input  wire logic [VALUE_W-1:0] left,
  input  wire logic [VALUE_W-1:0] right,
  input  wire logic [VALUE_W-1:0] head,
  output logic      [VALUE_W-1:0] data
);

  localparam logic [IW-1:0] MY = IW'(IDX);

  logic [VALUE_W-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (mode)
      M_KEEP: data_next = data;
      M_INS: begin
        if (MY == idx) begin
          data_next = new_value;
        end else if (MY > idx) begin
          data_next = left;
        end
      end
      M_DEL: begin
        if (MY >= idx) begin
          data_next = right;
        end
      end
      M_ROT: begin
        // The tail cell wraps the head around so the list comes back in order.
        data_next = (MY == tail) ? head : right;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire
